>>> rtl/dsc_pkg.sv
// ---------------------------------------------------------------------------
// dsc_pkg: shared types, constants and helpers for digit_split_count
// Holds the modulus, the register map and the link record between cells.
// ---------------------------------------------------------------------------
package dsc_pkg;

  // Field widths
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned WAYS_W  = 30;
  localparam int unsigned VALUE_W = 30;
  // Untruncated width of number * 10 + digit
  localparam int unsigned PROD_W  = 34;

  // Default length of the cell row (longest piece, in digits)
  localparam int unsigned MAX_PIECE_DIGITS_DEF = 10;

  // Count modulus and register reset value
  localparam logic [WAYS_W:0]    WAYS_MOD        = 31'd1000000007;
  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 30'd1000000000;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_VALUE = 2'd0;

  // What one cell hands to its neighbor
  typedef struct packed {
    logic               alive;
    logic [VALUE_W-1:0] number;
    logic [WAYS_W-1:0]  ways;
  } cell_link_t;

  // Sum of two residues, reduced once
  function automatic logic [WAYS_W-1:0] mod_add(input logic [WAYS_W-1:0] a,
                                                input logic [WAYS_W-1:0] b);
    logic [WAYS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WAYS_MOD) begin
      s = s - WAYS_MOD;
    end
    return s[WAYS_W-1:0];
  endfunction

endpackage

>>> rtl/digit_split_count.sv
// ---------------------------------------------------------------------------
// digit_split_count: streaming count of bounded splits of a digit string
// Counts the ways the digits seen so far split into pieces in 1..max_value
// without leading zeros, modulo 1000000007, one beat out per digit in.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | sink      | in_valid/in_stall  | in_digit, in_last_digit
//  out     | source    | out_valid/out_stall| out_ways_count, out_is_final
//  cfg     | sink      | APB psel/penable   | max_value at address 0
//
//  A result is registered when the sum walk of its beat is done:
//  the taking edge shifts the digit into the cell row, the partial sum walks
//  the row one cell a cycle, and the output register loads at the end of it.
//  in_stall is high from the taking edge until that load, so a new beat is
//  taken only after the previous result is loaded. A result waits in the output
//  register while the next item is worked on; only a second finished result
//  waits for out_stall. Reset clears every cell, sets the prefix count to one
//  and max_value to its default. A beat with the last-digit flag clears the
//  row again.
//
module digit_split_count
  import dsc_pkg::*;
#(
  parameter int unsigned MAX_PIECE_DIGITS = MAX_PIECE_DIGITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DIGIT_W-1:0]    in_digit,
  input  logic                  in_last_digit,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WAYS_W-1:0]     out_ways_count,
  output logic                  out_is_final,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CNT_W = $clog2(MAX_PIECE_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(MAX_PIECE_DIGITS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SUM  = 1'b1;

  logic               state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r;
  logic [WAYS_W-1:0]  prefix_r;
  logic [VALUE_W-1:0] max_value_r;
  logic               out_valid_r;
  logic [WAYS_W-1:0]  out_ways_r;
  logic               out_final_r;

  logic               in_take;
  logic               finish;
  logic               cfg_wr;

  cell_link_t         link [MAX_PIECE_DIGITS+1];
  logic [WAYS_W-1:0]  psum [MAX_PIECE_DIGITS+1];

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_MAX_VALUE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= MAX_VALUE_RESET;
    end else if (cfg_wr) begin
      max_value_r <= pwdata[VALUE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MAX_VALUE) begin
      prdata = {{(CFG_DATA_W-VALUE_W){1'b0}}, max_value_r};
    end
  end

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign finish   = (state_r == ST_SUM) && (cnt_r == CNT_DONE)
                  && (!out_valid_r || !out_stall);

  // sequencer: shift cycle, then sum walk
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_SUM;
          cnt_nxt   = '0;
        end
      end
      ST_SUM: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end else if (cnt_r != CNT_DONE) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      last_r <= in_last_digit;
    end
  end

  // prefix count: one for the empty prefix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= WAYS_W'(1);
    end else if (finish) begin
      prefix_r <= last_r ? WAYS_W'(1) : psum[MAX_PIECE_DIGITS];
    end
  end

  // new cell opens at the head of the row
  assign link[0] = '{alive: (in_digit != '0), number: '0, ways: prefix_r};
  assign psum[0] = '0;

  // cell row
  for (genvar i = 0; i < MAX_PIECE_DIGITS; i++) begin : g_cell
    dsc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (in_take),
      .clr       (finish && last_r),
      .digit     (in_digit),
      .max_value (max_value_r),
      .link_in   (link[i]),
      .psum_in   (psum[i]),
      .link_out  (link[i+1]),
      .psum_out  (psum[i+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ways_r  <= psum[MAX_PIECE_DIGITS];
      out_final_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ways_count = out_ways_r;
  assign out_is_final   = out_final_r;

  // checks
  a_take_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_SUM) && (cnt_r == '0))
    else $error("accepted beat did not start the sum walk");

  a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_ways_r} < WAYS_MOD))
    else $error("result count not reduced");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (state_r == ST_SUM) && in_stall)
    else $error("result taken outside the sum walk");

  a_prefix_reset_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && last_r) |=> (prefix_r == WAYS_W'(1)) && !link[1].alive)
    else $error("row not cleared after the last digit");

endmodule

>>> rtl/dsc_cell.sv
// ---------------------------------------------------------------------------
// dsc_cell: one cell of the split counter row
// Holds the partial number that starts at one recent position and the count
// of splits before that start; also one stage of the running sum chain.
// ---------------------------------------------------------------------------
module dsc_cell
  import dsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic               clr,
  input  logic [DIGIT_W-1:0] digit,
  input  logic [VALUE_W-1:0] max_value,
  input  cell_link_t         link_in,
  input  logic [WAYS_W-1:0]  psum_in,
  output cell_link_t         link_out,
  output logic [WAYS_W-1:0]  psum_out
);

  logic               alive_r;
  logic [VALUE_W-1:0] number_r;
  logic [WAYS_W-1:0]  ways_r;
  logic [WAYS_W-1:0]  psum_r;
  logic [PROD_W-1:0]  number_nxt;
  logic               fits;
  logic [WAYS_W-1:0]  contrib;

  // number * 10 + digit as two shifted copies plus the digit
  assign number_nxt = {1'b0, link_in.number, 3'b000}
                    + {3'b000, link_in.number, 1'b0}
                    + {{(PROD_W-DIGIT_W){1'b0}}, digit};
  assign fits = link_in.alive && (number_nxt <= {{(PROD_W-VALUE_W){1'b0}}, max_value});

  // alive flag: control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
    end else if (clr) begin
      alive_r <= 1'b0;
    end else if (upd) begin
      alive_r <= fits;
    end
  end

  // payload taken from the left neighbor on a new digit
  always_ff @(posedge clk) begin
    if (upd) begin
      number_r <= number_nxt[VALUE_W-1:0];
      ways_r   <= link_in.ways;
    end
  end

  // sum chain stage: adds this cell's start count when alive
  assign contrib = alive_r ? ways_r : '0;
  always_ff @(posedge clk) begin
    psum_r <= mod_add(psum_in, contrib);
  end

  assign link_out = '{alive: alive_r, number: number_r, ways: ways_r};
  assign psum_out = psum_r;

endmodule

>>> tb/tb_digit_split_count.sv
// ---------------------------------------------------------------------------
// tb_digit_split_count: self-checking bench for digit_split_count
// Streams digit strings with random gaps and output stalls, predicts the
// running split count of every beat and steps max_value through a range of
// values with its extremes between phases over the APB port, reading each back.
// ---------------------------------------------------------------------------
module tb_digit_split_count;
  import dsc_pkg::*;

  localparam int unsigned CELLS  = MAX_PIECE_DIGITS_DEF;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_DIGITS = 180;

  // One expected result beat
  typedef struct packed {
    logic [WAYS_W-1:0] ways;
    logic              fin;
  } count_beat_t;

  // Running split-count predictor and store of expected counts
  class ways_tracker;
    logic [VALUE_W-1:0] max_value;
    logic [PROD_W-1:0]  cell_number [CELLS];
    logic [WAYS_W-1:0]  cell_ways   [CELLS];
    logic               cell_alive  [CELLS];
    logic [WAYS_W-1:0]  prefix_ways;
    count_beat_t        expected_counts [$];
    int unsigned        mismatch_count;

    function new();
      max_value      = MAX_VALUE_RESET;
      mismatch_count = 0;
      clear_cells();
    endfunction

    // Empty row; the empty prefix has one split
    function void clear_cells();
      for (int i = 0; i < CELLS; i++) begin
        cell_number[i] = '0;
        cell_ways[i]   = '0;
        cell_alive[i]  = 1'b0;
      end
      prefix_ways = WAYS_W'(1);
    endfunction

    function void set_max_value(logic [CFG_DATA_W-1:0] data);
      max_value = data[VALUE_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
    endtask

    // Accepted digit: shift the row, open a cell, extend live numbers
    function void note_digit(logic [DIGIT_W-1:0] digit, logic last);
      logic [63:0] total;
      count_beat_t beat;
      total = '0;
      for (int i = CELLS - 1; i > 0; i--) begin
        cell_number[i] = cell_number[i-1];
        cell_ways[i]   = cell_ways[i-1];
        cell_alive[i]  = cell_alive[i-1];
      end
      cell_number[0] = '0;
      cell_ways[0]   = prefix_ways;
      // a piece may not start on a zero
      cell_alive[0]  = (digit != 0);
      for (int i = 0; i < CELLS; i++) begin
        if (cell_alive[i]) begin
          cell_number[i] = cell_number[i] * 10 + digit;
          if (cell_number[i] > max_value) begin
            cell_alive[i] = 1'b0;
          end else begin
            total += cell_ways[i];
          end
        end
      end
      prefix_ways = WAYS_W'(total % WAYS_MOD);
      beat.ways = prefix_ways;
      beat.fin  = last;
      expected_counts.push_back(beat);
      if (last) begin
        clear_cells();
      end
    endfunction

    // Result beat against the oldest expected count
    task check_count(logic [WAYS_W-1:0] ways, logic fin);
      count_beat_t want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: ways_count %0d is_final %0b", ways, fin));
        return;
      end
      want = expected_counts.pop_front();
      if (ways !== want.ways) begin
        report_mismatch($sformatf("ways_count %0d, predicted %0d", ways, want.ways));
      end
      if (fin !== want.fin) begin
        report_mismatch($sformatf("is_final %0b, predicted %0b", fin, want.fin));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [DIGIT_W-1:0]    in_digit;
  logic                  in_last_digit;
  logic                  out_valid;
  logic                  out_stall;
  logic [WAYS_W-1:0]     out_ways_count;
  logic                  out_is_final;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ways_tracker board;
  int unsigned gap_pct   = 32;
  int unsigned stall_pct = 32;
  int unsigned sent;

  digit_split_count #(
    .MAX_PIECE_DIGITS(CELLS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_digit       (in_digit),
    .in_last_digit  (in_last_digit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ways_count (out_ways_count),
    .out_is_final   (out_is_final),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  // Random stall on the result side
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Beats are taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.note_digit(in_digit, in_last_digit);
    end
    if (rst_n && out_valid && !out_stall) begin
      board.check_count(out_ways_count, out_is_final);
    end
  end

  // Hold the input off until every expected count has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // One digit beat, with a random gap in front
  task automatic send_digit(input logic [DIGIT_W-1:0] digit, input logic last);
    if ($urandom_range(99) < 3) begin
      wait_drained();
    end
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_digit      = digit;
    in_last_digit = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Random string, closed by the last-digit flag
  task automatic send_string(input bit noisy);
    int unsigned len;
    int unsigned roll;
    logic [DIGIT_W-1:0] digit;
    roll = $urandom_range(99);
    if (roll < 80) len = $urandom_range(12, 1);
    else if (roll < 95) len = $urandom_range(30, 13);
    else len = $urandom_range(60, 31);
    for (int unsigned k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (noisy) digit = DIGIT_W'($urandom_range(15, 0));
      else if (roll < 78) digit = DIGIT_W'($urandom_range(9, 1));
      else if (roll < 96) digit = '0;
      else digit = DIGIT_W'($urandom_range(15, 10));
      send_digit(digit, k == len - 1);
    end
  endtask

  // Write max_value while idle, then read it back
  task automatic write_max_value(input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] back;
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_MAX_VALUE;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    board.set_max_value(data);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    back = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (back !== {{(CFG_DATA_W - VALUE_W){1'b0}}, data[VALUE_W-1:0]}) begin
      board.report_mismatch($sformatf("max_value read back %0d, wrote %0d",
                                      back, data[VALUE_W-1:0]));
    end
  endtask

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] limits [PHASES];
    board         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_digit      = '0;
    in_last_digit = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sent          = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Default limit: exact 1000000000, then a piece longer than the row
    send_digit(4'd1, 1'b0);
    repeat (9) send_digit(4'd0, 1'b0);
    send_digit(4'd9, 1'b1);
    // Lone zero
    send_digit(4'd0, 1'b1);
    // Raw digits above nine, then a zero that cannot start a piece
    send_digit(4'd15, 1'b0);
    send_digit(4'd10, 1'b0);
    send_digit(4'd0, 1'b0);
    send_digit(4'd9, 1'b1);
    // No piece fits
    write_max_value(32'd0);
    send_digit(4'd3, 1'b0);
    send_digit(4'd7, 1'b1);
    // Smallest usable limit
    write_max_value(32'd1);
    send_digit(4'd1, 1'b0);
    send_digit(4'd1, 1'b0);
    send_digit(4'd0, 1'b0);
    send_digit(4'd1, 1'b1);

    // Random strings over a range of limits
    limits = '{32'd1000000000, 32'd9, 32'd1, 32'd0, 32'hFFFF_FFFF,
               32'd26, 32'd999, 32'd123456789, 32'd0, 32'd1000000000};
    limits[8] = $urandom_range(1000000000, 1);
    for (int ph = 0; ph < PHASES; ph++) begin
      write_max_value(limits[ph]);
      // one long stretch with the gap and stall rates at zero
      gap_pct   = (ph == 7) ? 0 : 32;
      stall_pct = (ph == 7) ? 0 : 32;
      sent = 0;
      while (sent < PHASE_DIGITS) begin
        send_string($urandom_range(99) < 10);
      end
    end
    gap_pct   = 32;
    stall_pct = 32;

    wait_drained();
    repeat (4 * CELLS) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> digit_split_count.f
rtl/dsc_pkg.sv
rtl/dsc_cell.sv
rtl/digit_split_count.sv
tb/tb_digit_split_count.sv
